FILE: hw/rtl/titr_pkg.sv
// Package for the texture intern table: field widths, codes, reset values
// and the sizing helper for the match reduction tree. No dependencies.
`default_nettype none

package titr_pkg;

	// Default values of the top level parameters.
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int SLOT_COUNT_DEF  = 5;
	localparam int KEY_WIDTH_DEF   = 32;

	// Fixed widths of the channel fields.
	localparam int KEY_IN_W    = 32;
	localparam int SLOT_W      = 3;
	localparam int INDEX_OUT_W = 8;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 9;
	localparam int REJ_W       = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WHITE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] WHITE_KEY_RST  = 32'd1;
	localparam logic [CFG_DATA_W-1:0] NORMAL_KEY_RST = 32'd2;
	localparam logic                  LIMIT_RST      = 1'b1;

	// Request function codes.
	localparam logic FUNC_CLEAR  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// The slot whose unbound texture becomes the flat normal.
	localparam logic [SLOT_W-1:0] NORMAL_SLOT = 3'd1;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STAT_FOUND    = 2'd0;
	localparam status_t STAT_INSERTED = 2'd1;
	localparam status_t STAT_REJECTED = 2'd2;
	localparam status_t STAT_SKIPPED  = 2'd3;

	// Levels of the fan-in-16 reduction tree over the match bits.
	function automatic int titr_tree_levels(input int depth);
		return ($clog2(depth) + 3) / 4;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/titr_if.sv
// Request and result channel interfaces of the texture intern table.
// Depends on titr_pkg for the field widths.
`default_nettype none

interface titr_req_if;
	import titr_pkg::*;

	logic                valid;
	logic                ready;
	logic                func;
	logic [SLOT_W-1:0]   slot_index;
	logic [KEY_IN_W-1:0] texture_key;

	modport source (output valid, func, slot_index, texture_key, input ready);
	modport sink (input valid, func, slot_index, texture_key, output ready);
endinterface

interface titr_rsp_if;
	import titr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [INDEX_OUT_W-1:0] table_index;
	logic [STATUS_W-1:0]    status;
	logic                   decal_done;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic [REJ_W-1:0]       rejected_decals;

	modport source (output valid, table_index, status, decal_done, entry_count,
		rejected_decals, input ready);
	modport sink (input valid, table_index, status, decal_done, entry_count,
		rejected_decals, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/titr_cell.sv
// One table entry: holds a key, takes writes addressed to it and registers
// whether it is live and matches the broadcast search key. Uses titr_pkg.
`default_nettype none

module titr_cell #(
	parameter int KEY_WIDTH = titr_pkg::KEY_WIDTH_DEF,
	parameter int IDX_W     = 8,
	parameter int CNT_W     = 9,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_WIDTH-1:0] search_key,
	input  logic [CNT_W-1:0]     count,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [KEY_WIDTH-1:0] wr_key,
	output logic                 hit_s1
);
	import titr_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 live;

	// An entry only counts while it lies below the number of keys held.
	assign live = CNT_W'(IDX) < count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_WIDTH'(WHITE_KEY_RST);
		end else if (wr_en && (wr_addr == IDX_W'(IDX))) begin
			key_q <= wr_key;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1 <= live && (key_q == search_key);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/titr_tree.sv
// Registered fan-in-16 OR tree that turns the row of match bits into a hit
// flag and the index of the matching entry. Uses titr_pkg for its sizing.
`default_nettype none

module titr_tree #(
	parameter int LEAVES = titr_pkg::TABLE_DEPTH_DEF,
	parameter int IDX_W  = 8
) (
	input  logic              clk,
	input  logic [LEAVES-1:0] hit,
	output logic              root_hit,
	output logic [IDX_W-1:0]  root_index
);
	import titr_pkg::*;

	localparam int FAN_BITS = 4;
	localparam int FAN      = 1 << FAN_BITS;
	localparam int LEVELS   = titr_tree_levels(LEAVES);
	localparam int PAD      = 1 << (FAN_BITS * LEVELS);

	// Held keys are unique, so at most one leaf is set and an OR of the
	// absolute indices gives the index of the match.
	logic [IDX_W:0] leaf [PAD];
	logic [IDX_W:0] node_q [1:LEVELS][PAD];

	for (genvar i = 0; i < PAD; i++) begin : g_leaf
		if (i < LEAVES) begin : g_real
			always_comb begin
				leaf[i] = hit[i] ? {1'b1, IDX_W'(i)} : '0;
			end
		end else begin : g_pad
			always_comb begin
				leaf[i] = '0;
			end
		end
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		for (genvar n = 0; n < PAD; n++) begin : g_node
			if (n < (PAD >> (FAN_BITS * l))) begin : g_reg
				logic [IDX_W:0] orv;
				always_comb begin
					orv = '0;
					for (int k = 0; k < FAN; k++) begin
						if (l == 1) begin
							orv = orv | leaf[n * FAN + k];
						end else begin
							orv = orv | node_q[(l > 1) ? l - 1 : 1][n * FAN + k];
						end
					end
				end
				always_ff @(posedge clk) begin
					node_q[l][n] <= orv;
				end
			end else begin : g_unused
				always_comb begin
					node_q[l][n] = '0;
				end
			end
		end
	end

	assign root_hit   = node_q[LEVELS][0][IDX_W];
	assign root_index = node_q[LEVELS][0][IDX_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/texture_intern_table_with_rollback.sv
// Texture intern table with per-decal rollback: top level with the sequencer, the row of key
// cells and the match tree. Uses titr_pkg, titr_if, titr_cell and titr_tree.
// A lookup passes the search key register, the cell match register, the registered OR tree
// levels and the pending result register on its way to the output register; a clear, a skipped
// slot or an out-of-range slot needs no search. A new request is taken only once the last result
// has moved into the output register. Reset: one key held, entry 0 the reset white key.
`default_nettype none

module texture_intern_table_with_rollback #(
	parameter int TABLE_DEPTH = titr_pkg::TABLE_DEPTH_DEF,
	parameter int SLOT_COUNT  = titr_pkg::SLOT_COUNT_DEF,
	parameter int KEY_WIDTH   = titr_pkg::KEY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [titr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [titr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	titr_req_if.sink                         req,
	titr_rsp_if.source                       rsp
);
	import titr_pkg::*;

	// The table lives in a row of identical cells, one per entry. A search
	// broadcasts the resolved key to every cell; each cell registers whether
	// it is live (below the held count) and matches. Because a key is only
	// appended after a miss, at most one live cell can match, so the tree
	// simply ORs the indices of matching cells towards a single root.

	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TREE_LEVELS = titr_tree_levels(TABLE_DEPTH);
	localparam int WAIT_W      = $clog2(TREE_LEVELS + 2);
	localparam int SLOT_CMP_W  = SLOT_W + 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_DONE   = 2'd2;

	logic [1:0]             state_q;
	logic [WAIT_W-1:0]      wait_q;

	logic [CFG_DATA_W-1:0]  white_q;
	logic [CFG_DATA_W-1:0]  normal_q;
	logic                   limit_q;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       start_q;
	logic                   rejecting_q;
	logic [REJ_W-1:0]       rej_q;

	logic [KEY_WIDTH-1:0]   key_q;
	logic                   last_q;
	logic [INDEX_OUT_W-1:0] res_index_q;
	status_t                res_status_q;
	logic                   res_done_q;

	logic                   rsp_valid_q;
	logic [INDEX_OUT_W-1:0] rsp_index_q;
	status_t                rsp_status_q;
	logic                   rsp_done_q;
	logic [COUNT_OUT_W-1:0] rsp_count_q;
	logic [REJ_W-1:0]       rsp_rej_q;

	logic                   accept;
	logic [SLOT_CMP_W-1:0]  slot_ext;
	logic                   slot_ok;
	logic                   is_clear;
	logic                   short_path;
	logic [KEY_IN_W-1:0]    key_pick;
	logic                   search_done;
	logic                   full;
	logic                   rsp_load;

	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [KEY_WIDTH-1:0]   wr_key;
	logic [TABLE_DEPTH-1:0] hit_s1;
	logic                   root_hit;
	logic [IDX_W-1:0]       root_index;

	// One request at a time is in the table; a finished result may still
	// wait in the output register while the next request is being searched.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign slot_ext = {1'b0, req.slot_index};
	assign slot_ok  = slot_ext < SLOT_CMP_W'(SLOT_COUNT);
	assign is_clear = (req.func == FUNC_CLEAR);

	// Requests that need no search: a clear, a slot beyond the decal, and a
	// later slot of a decal that has already been rejected.
	assign short_path = is_clear || !slot_ok ||
		((req.slot_index != '0) && rejecting_q);

	// An unbound texture stands for the flat normal on the normal slot and
	// for white everywhere else.
	always_comb begin
		if (req.texture_key == '0) begin
			key_pick = (req.slot_index == NORMAL_SLOT) ? normal_q : white_q;
		end else begin
			key_pick = req.texture_key;
		end
	end

	// The root reflects the current search once the cell register and all
	// tree levels have been passed.
	assign search_done = (state_q == S_SEARCH) && (wait_q == WAIT_W'(TREE_LEVELS + 1));
	assign full        = count_q >= CNT_W'(TABLE_DEPTH);
	assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// Cell writes: a clear puts the current white key into entry 0, a miss
	// with room left appends the search key at the held count.
	always_comb begin
		if (accept && is_clear) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_key  = KEY_WIDTH'(white_q);
		end else begin
			wr_en   = search_done && !root_hit && !full;
			wr_addr = count_q[IDX_W-1:0];
			wr_key  = key_q;
		end
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		titr_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.IDX_W     (IDX_W),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.search_key (key_q),
			.count      (count_q),
			.wr_en      (wr_en),
			.wr_addr    (wr_addr),
			.wr_key     (wr_key),
			.hit_s1     (hit_s1[i])
		);
	end

	titr_tree #(
		.LEAVES (TABLE_DEPTH),
		.IDX_W  (IDX_W)
	) u_tree (
		.clk        (clk),
		.hit        (hit_s1),
		.root_hit   (root_hit),
		.root_index (root_index)
	);

	// Sequencer, configuration registers and the table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= '0;
			white_q     <= WHITE_KEY_RST;
			normal_q    <= NORMAL_KEY_RST;
			limit_q     <= LIMIT_RST;
			count_q     <= CNT_W'(1);
			start_q     <= CNT_W'(1);
			rejecting_q <= 1'b0;
			rej_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WHITE: begin
						white_q <= cfg_wdata;
					end
					REG_NORMAL: begin
						normal_q <= cfg_wdata;
					end
					REG_LIMIT: begin
						limit_q <= cfg_wdata[0];
					end
					default: begin
					end
				endcase
			end

			// A new result replaces the one leaving in the same cycle.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						wait_q <= '0;
						if (is_clear) begin
							count_q     <= CNT_W'(1);
							start_q     <= CNT_W'(1);
							rejecting_q <= 1'b0;
							rej_q       <= '0;
						end else if (slot_ok && (req.slot_index == '0)) begin
							// A new decal: remember where to roll back to.
							start_q     <= count_q;
							rejecting_q <= 1'b0;
						end
						state_q <= short_path ? S_DONE : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (search_done) begin
						state_q <= S_DONE;
						if (!root_hit) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end else if (limit_q) begin
								// Table full: drop everything this decal added.
								count_q     <= start_q;
								rejecting_q <= 1'b1;
								if (rej_q != '1) begin
									rej_q <= rej_q + REJ_W'(1);
								end
							end
						end
					end else begin
						wait_q <= wait_q + WAIT_W'(1);
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Search key, pending result and the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q        <= KEY_WIDTH'(key_pick);
			last_q       <= slot_ext == SLOT_CMP_W'(SLOT_COUNT - 1);
			res_index_q  <= '0;
			res_status_q <= STAT_SKIPPED;
			res_done_q   <= 1'b0;
		end
		if (search_done) begin
			if (root_hit) begin
				res_index_q  <= INDEX_OUT_W'(root_index);
				res_status_q <= STAT_FOUND;
				res_done_q   <= last_q;
			end else if (!full) begin
				res_index_q  <= INDEX_OUT_W'(count_q);
				res_status_q <= STAT_INSERTED;
				res_done_q   <= last_q;
			end else if (limit_q) begin
				res_index_q  <= '0;
				res_status_q <= STAT_REJECTED;
				res_done_q   <= 1'b1;
			end else begin
				// Limit off: the key is not stored and gets the last index.
				res_index_q  <= INDEX_OUT_W'(TABLE_DEPTH - 1);
				res_status_q <= STAT_INSERTED;
				res_done_q   <= last_q;
			end
		end
		if (rsp_load) begin
			rsp_index_q  <= res_index_q;
			rsp_status_q <= res_status_q;
			rsp_done_q   <= res_done_q;
			rsp_count_q  <= COUNT_OUT_W'(count_q);
			rsp_rej_q    <= rej_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.table_index     = rsp_index_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.decal_done      = rsp_done_q;
	assign rsp.entry_count     = rsp_count_q;
	assign rsp.rejected_decals = rsp_rej_q;

endmodule

`default_nettype wire

FILE: hw/rtl/titr_checker.sv
// Port-level checks on the result channel of the texture intern table, and
// the bind that attaches them to the top level. Uses titr_pkg.
`default_nettype none

module titr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             rsp_valid,
	input wire logic                             rsp_ready,
	input wire logic [titr_pkg::INDEX_OUT_W-1:0] table_index,
	input wire logic [titr_pkg::STATUS_W-1:0]    status,
	input wire logic                             decal_done,
	input wire logic [titr_pkg::COUNT_OUT_W-1:0] entry_count,
	input wire logic [titr_pkg::REJ_W-1:0]       rejected_decals
);
	import titr_pkg::*;

	// A stalled result keeps its whole payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid &&
		$stable({table_index, status, decal_done, entry_count, rejected_decals}))
		else $error("result changed while stalled");

	// A rejection always closes the decal and names no entry.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_REJECTED) |-> decal_done && (table_index == '0))
		else $error("rejection without decal end or with an index");

	// An inserted key is the last one held.
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_INSERTED) |->
		table_index == INDEX_OUT_W'(entry_count - COUNT_OUT_W'(1)))
		else $error("inserted index is not the last entry");

	// A found key lies within the entries held.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FOUND) |-> {1'b0, table_index} < entry_count)
		else $error("found index beyond the held entries");

endmodule

bind texture_intern_table_with_rollback titr_checker u_titr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.table_index     (rsp.table_index),
	.status          (rsp.status),
	.decal_done      (rsp.decal_done),
	.entry_count     (rsp.entry_count),
	.rejected_decals (rsp.rejected_decals)
);

`default_nettype wire

FILE: tb/texture_intern_table_with_rollback_test.sv
// Self-checking testbench for the texture intern table with per-decal rollback.
// Drives lookup and clear requests through titr_req_if, checks every answer on
// titr_rsp_if against its table model or a hand-written answer; needs titr_pkg and titr_if.

module texture_intern_table_with_rollback_test;
	timeunit 1ns;
	timeprecision 1ps;

	import titr_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int SLOTS = SLOT_COUNT_DEF;

	// One answer of the block, field by field at the port widths.
	typedef struct packed {
		logic [INDEX_OUT_W-1:0] table_index;
		status_t                status;
		logic                   decal_done;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [REJ_W-1:0]       rejected_decals;
	} answer_t;

	// A row of the opening script. Where typed is set, want is the answer
	// written out by hand; otherwise the answer comes from the table model.
	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       key;
		bit                typed;
		answer_t           want;
	} script_row_t;

	localparam answer_t NO_ANSWER = '0;
	// Every clear, and an ignored slot straight after one, answers like this.
	localparam answer_t CLEARED = '{8'd0, STAT_SKIPPED, 1'b0, 9'd1, 16'd0};

	// Opening script, run with the reset register values (white key 1,
	// normal key 2, limit on). Rejections, skipped slots and the overflow
	// with the limit off need a full table and are reached later.
	localparam int OPENING_ROWS = 21;
	localparam script_row_t OPENING [OPENING_ROWS] = '{
		// An unbound texture on slot 0 is the white key, held at entry 0.
		'{FUNC_LOOKUP, 3'd0, 32'h0000_0000, 1'b1, '{8'd0, STAT_FOUND, 1'b0, 9'd1, 16'd0}},
		// An unbound texture on slot 1 is the normal key, which gets appended.
		'{FUNC_LOOKUP, 3'd1, 32'h0000_0000, 1'b1, '{8'd1, STAT_INSERTED, 1'b0, 9'd2, 16'd0}},
		'{FUNC_LOOKUP, 3'd2, 32'hFFFF_FFFF, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd3, 32'h0000_0001, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd4, 32'h0000_0002, 1'b0, NO_ANSWER},
		// Slots past the last one are ignored.
		'{FUNC_LOOKUP, 3'd5, 32'h1234_5678, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd6, 32'hFFFF_FFFF, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd7, 32'h0000_0000, 1'b0, NO_ANSWER},
		'{FUNC_CLEAR,  3'd0, 32'h0000_0000, 1'b1, CLEARED},
		'{FUNC_LOOKUP, 3'd7, 32'h0000_0005, 1'b1, CLEARED},
		// A clear ignores its slot and key fields.
		'{FUNC_CLEAR,  3'd7, 32'hFFFF_FFFF, 1'b1, CLEARED},
		// A decal picked up in the middle, with no slot 0 before it.
		'{FUNC_LOOKUP, 3'd3, 32'h0000_0000, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd0, 32'h8000_0000, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd1, 32'h0000_0002, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd2, 32'h0000_0000, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd1, 32'h0000_0000, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd4, 32'h8000_0000, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd4, 32'h0000_0001, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd0, 32'h7FFF_FFFF, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd2, 32'h5555_5555, 1'b0, NO_ANSWER},
		'{FUNC_LOOKUP, 3'd3, 32'hAAAA_AAAA, 1'b0, NO_ANSWER}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	titr_req_if req_ch();
	titr_rsp_if rsp_ch();

	texture_intern_table_with_rollback dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Model of the table: its own copy of the keys, the counts and the
	// register values, advanced once for every request the block takes.
	logic [31:0] model_keys [DEPTH];
	int          held_keys;
	int          decal_start_count;
	bit          decal_rejected;
	logic [15:0] reject_tally;
	logic [31:0] white_reg;
	logic [31:0] normal_reg;
	bit          limit_reg;

	answer_t awaited_answers [$];

	int requests_sent;
	int answers_checked;
	int mismatches;
	int status_seen [4];

	// Shared between the stimulus and the answer side.
	int holds_wanted;
	bit rx_steady;

	// Sender burst state, only touched by the stimulus process.
	bit gaps_on;
	int burst_left;

	task automatic reset_model();
		white_reg = WHITE_KEY_RST;
		normal_reg = NORMAL_KEY_RST;
		limit_reg = LIMIT_RST;
		model_keys[0] = white_reg;
		held_keys = 1;
		decal_start_count = 1;
		decal_rejected = 1'b0;
		reject_tally = '0;
	endtask

	// Works out the answer to one request and moves the model on.
	function automatic answer_t intern_lookup(input logic func, input logic [SLOT_W-1:0] slot,
			input logic [31:0] key);
		answer_t ans;
		logic [31:0] wanted_key;
		bit hit;
		int pos;
		ans = '{8'd0, STAT_SKIPPED, 1'b0, 9'd0, 16'd0};
		hit = 1'b0;
		pos = 0;
		if (func == FUNC_CLEAR) begin
			// The white key is taken as it stands at the moment of the clear.
			model_keys[0] = white_reg;
			held_keys = 1;
			decal_start_count = 1;
			decal_rejected = 1'b0;
			reject_tally = '0;
		end else if (slot < SLOTS) begin
			if (slot == 0) begin
				decal_start_count = held_keys;
				decal_rejected = 1'b0;
			end
			// Once a decal has been rejected its later slots change nothing.
			if (slot == 0 || !decal_rejected) begin
				if (key != 0)
					wanted_key = key;
				else if (slot == NORMAL_SLOT)
					wanted_key = normal_reg;
				else
					wanted_key = white_reg;
				ans.decal_done = (slot == SLOTS - 1);
				for (int i = 0; i < held_keys; i++) begin
					if (!hit && model_keys[i] == wanted_key) begin
						hit = 1'b1;
						pos = i;
					end
				end
				if (hit) begin
					ans.table_index = pos[INDEX_OUT_W-1:0];
					ans.status = STAT_FOUND;
				end else if (held_keys >= DEPTH) begin
					if (limit_reg) begin
						// Roll the whole decal back to where it started.
						held_keys = decal_start_count;
						decal_rejected = 1'b1;
						if (reject_tally != 16'hFFFF)
							reject_tally++;
						ans.status = STAT_REJECTED;
						ans.decal_done = 1'b1;
					end else begin
						// No room and no limit: the key is dropped and the
						// last index is given.
						ans.table_index = INDEX_OUT_W'(DEPTH - 1);
						ans.status = STAT_INSERTED;
					end
				end else begin
					model_keys[held_keys] = wanted_key;
					ans.table_index = held_keys[INDEX_OUT_W-1:0];
					ans.status = STAT_INSERTED;
					held_keys++;
				end
			end
		end
		ans.entry_count = held_keys[COUNT_OUT_W-1:0];
		ans.rejected_decals = reject_tally;
		return ans;
	endfunction

	// Mostly fresh keys so the table fills, with some unbound textures,
	// some keys already held and some explicit default keys.
	function automatic logic [31:0] pick_key(input int slot);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 32'd0;
		else if (roll < 18)
			return model_keys[$urandom_range(0, held_keys - 1)];
		else if (roll < 22)
			return (slot == NORMAL_SLOT) ? normal_reg : white_reg;
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got_v,
			input longint unsigned want_v);
		mismatches++;
		$display("%0t ns: %s wrong on answer %0d: got 0x%0h, expected 0x%0h",
			$time, what, answers_checked, got_v, want_v);
	endtask

	// Offers one request, holding it until the block takes it, then records
	// the answer it should produce. Between bursts the sender goes quiet;
	// some bursts are long enough to count as no idling at all.
	task automatic present_request(input logic func, input logic [SLOT_W-1:0] slot,
			input logic [31:0] key, input bit typed, input answer_t want);
		answer_t ans;
		if (gaps_on && burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= func;
		req_ch.slot_index <= slot;
		req_ch.texture_key <= key;
		do
			@(posedge clk);
		while (!req_ch.ready);
		ans = intern_lookup(func, slot, key);
		awaited_answers.insert(awaited_answers.size(), typed ? want : ans);
		burst_left--;
		requests_sent++;
	endtask

	// Drops valid and waits for every outstanding answer. Each request has
	// exactly one answer, so the block is idle once the last one is in.
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_WHITE: white_reg = data;
			REG_NORMAL: normal_reg = data;
			REG_LIMIT: limit_reg = data[0];
			default: ;
		endcase
	endtask

	// Random traffic. Most of it is whole decals, slot 0 to the last slot;
	// the rest is decals cut short or entered midway, ignored slot numbers
	// and, where clear_pct allows, clears. With fill_table set it runs on
	// until the table is full and a dozen decals have been turned away, or max_items is reached.
	task automatic run_mix(input int min_items, input int max_items, input bit fill_table,
			input int clear_pct);
		int base;
		int roll;
		int lo_slot;
		int hi_slot;
		base = requests_sent;
		while ((requests_sent - base) < max_items && ((requests_sent - base) < min_items
				|| (fill_table && (held_keys < DEPTH || reject_tally < 12)))) begin
			roll = $urandom_range(0, 99);
			if (roll < clear_pct) begin
				present_request(FUNC_CLEAR, SLOT_W'($urandom_range(0, 7)), $urandom, 1'b0,
					NO_ANSWER);
			end else if (roll < 10) begin
				present_request(FUNC_LOOKUP, SLOT_W'($urandom_range(SLOTS, 7)), $urandom, 1'b0,
					NO_ANSWER);
			end else begin
				lo_slot = 0;
				hi_slot = SLOTS - 1;
				if (roll < 22) begin
					lo_slot = $urandom_range(0, SLOTS - 1);
					hi_slot = $urandom_range(lo_slot, SLOTS - 1);
				end
				for (int s = lo_slot; s <= hi_slot; s++)
					present_request(FUNC_LOOKUP, SLOT_W'(s), pick_key(s), 1'b0, NO_ANSWER);
			end
		end
	endtask

	// Answer side: the ready pattern steps in turn through always ready, a
	// coin toss, ready a third of the time and mostly ready. A requested
	// hold-off keeps ready low so that the block backs up into its request
	// channel.
	initial begin : answer_pacing
		int hold_left;
		int holds_served;
		int tick;
		hold_left = 0;
		holds_served = 0;
		tick = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left == 0 && holds_served < holds_wanted) begin
				hold_left = 300;
				holds_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_steady) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				case ((tick / 64) % 4)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (tick % 3 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// Every answer taken is checked against the oldest one awaited.
	always @(posedge clk) begin : answer_check
		answer_t got;
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.table_index, rsp_ch.status, rsp_ch.decal_done, rsp_ch.entry_count,
				rsp_ch.rejected_decals};
			status_seen[got.status]++;
			if (awaited_answers.size() == 0) begin
				report_mismatch("unrequested answer", 64'(got), 64'd0);
			end else begin
				want = awaited_answers.pop_front();
				if (got.table_index !== want.table_index)
					report_mismatch("table_index", 64'(got.table_index),
						64'(want.table_index));
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.decal_done !== want.decal_done)
					report_mismatch("decal_done", 64'(got.decal_done), 64'(want.decal_done));
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(got.entry_count),
						64'(want.entry_count));
				if (got.rejected_decals !== want.rejected_decals)
					report_mismatch("rejected_decals", 64'(got.rejected_decals),
						64'(want.rejected_decals));
			end
			answers_checked++;
		end
	end

	initial begin : stimulus
		requests_sent = 0;
		answers_checked = 0;
		mismatches = 0;
		status_seen = '{0, 0, 0, 0};
		gaps_on = 1'b1;
		burst_left = 0;
		holds_wanted <= 0;
		rx_steady <= 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WHITE;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_CLEAR;
		req_ch.slot_index <= '0;
		req_ch.texture_key <= '0;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[r])
			present_request(OPENING[r].func, OPENING[r].slot, OPENING[r].key, OPENING[r].typed,
				OPENING[r].want);
		settle();

		// Random default keys with the limit on. A clear loads the new white
		// key, then the table is filled until a dozen decals have been rejected.
		// Early on the answer side holds off for a long stretch.
		write_reg(REG_WHITE, $urandom_range(1, 32'hFFFF_FFFF));
		write_reg(REG_NORMAL, $urandom_range(1, 32'hFFFF_FFFF));
		write_reg(REG_LIMIT, 32'd1);
		cfg_we <= 1'b0;
		holds_wanted <= 1;
		present_request(FUNC_CLEAR, 3'd0, 32'd0, 1'b0, NO_ANSWER);
		run_mix(200, 1200, 1'b1, 0);
		settle();

		// Extreme default keys. With the table full, decals that each bring
		// a new key are turned away; this stretch runs flat out with no
		// idling on either side.
		write_reg(REG_WHITE, 32'hFFFF_FFFF);
		write_reg(REG_NORMAL, 32'h0000_0001);
		write_reg(REG_LIMIT, 32'd1);
		cfg_we <= 1'b0;
		gaps_on = 1'b0;
		rx_steady <= 1'b1;
		repeat (6)
			present_request(FUNC_LOOKUP, 3'd0, $urandom, 1'b0, NO_ANSWER);
		// A skipped slot of the last rejected decal, then a hit.
		present_request(FUNC_LOOKUP, 3'd2, 32'd0, 1'b0, NO_ANSWER);
		present_request(FUNC_LOOKUP, 3'd0, model_keys[0], 1'b0, NO_ANSWER);
		settle();

		// Limit off: new keys meeting the full table are dropped, and the
		// occasional clear starts the table again.
		write_reg(REG_WHITE, 32'h0000_0001);
		write_reg(REG_NORMAL, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 32'd0);
		cfg_we <= 1'b0;
		gaps_on = 1'b1;
		rx_steady <= 1'b0;
		holds_wanted <= 2;
		run_mix(40, 40, 1'b0, 4);
		settle();
		repeat (20) @(posedge clk);

		$display("Ran %0d requests through four register settings, %0d answers checked.",
			requests_sent, answers_checked);
		$display("Answers seen: %0d found, %0d inserted, %0d rejected, %0d skipped or cleared.",
			status_seen[STAT_FOUND], status_seen[STAT_INSERTED], status_seen[STAT_REJECTED],
			status_seen[STAT_SKIPPED]);
		if (mismatches == 0 && awaited_answers.size() == 0) begin
			$display("texture_intern_table_with_rollback_test OK");
		end else begin
			$display("texture_intern_table_with_rollback_test NOT OK");
		end
		$finish;
	end

	// Even the longest possible run, every request stalled by the slowest
	// answer pattern, stays well within the time allowed here.
	initial begin : watchdog
		#2ms;
		$display("Timed out with %0d answers still awaited.", awaited_answers.size());
		$display("texture_intern_table_with_rollback_test NOT OK");
		$finish;
	end

endmodule
